// ===== hdl/sopo_pkg.sv =====
`timescale 1ns / 1ps
package sopo_pkg;

    localparam int MAX_LEN_DEFAULT = 256;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERLAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_RATE = 1'b1;

    localparam logic [8:0] MIN_OVERLAP_RESET = 9'd10;
    localparam logic [15:0] MISMATCH_RATE_RESET = 16'd1311;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TEST,
        ST_SCAN,
        ST_MUL,
        ST_JUDGE,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic init_len;
        logic start_scan;
        logic scan_issue;
        logic mul;
        logic next_len;
        logic set_found;
        logic set_none;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_req;
        logic len_lt_shorter;
        logic scan_done;
        logic accept_ok;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== hdl/sopo_word_if.sv =====
`timescale 1ns / 1ps
interface sopo_word_if;
    logic        valid;
    logic        ready;
    logic        which_sequence;
    logic [7:0]  base;
    logic        last;
    logic [9:0]  clip_count;
    logic [30:0] clip_position;
    logic [8:0]  local_clip_position;
    logic [15:0] reference_id;

    modport source
    (
        output valid, which_sequence, base, last, clip_count, clip_position,
               local_clip_position, reference_id,
        input  ready
    );
    modport sink
    (
        input  valid, which_sequence, base, last, clip_count, clip_position,
               local_clip_position, reference_id,
        output ready
    );
endinterface

// ===== hdl/sopo_result_if.sv =====
`timescale 1ns / 1ps
interface sopo_result_if;
    logic              valid;
    logic              ready;
    logic              found;
    logic [7:0]        overlap_length;
    logic [7:0]        mismatch_count;
    logic [15:0]       result_reference;
    logic [30:0]       first_clip_position;
    logic [30:0]       second_clip_position;
    logic [9:0]        first_clip_count;
    logic [9:0]        second_clip_count;
    logic signed [9:0] estimated_length;

    modport source
    (
        output valid, found, overlap_length, mismatch_count, result_reference,
               first_clip_position, second_clip_position, first_clip_count,
               second_clip_count, estimated_length,
        input  ready
    );
    modport sink
    (
        input  valid, found, overlap_length, mismatch_count, result_reference,
               first_clip_position, second_clip_position, first_clip_count,
               second_clip_count, estimated_length,
        output ready
    );
endinterface

// ===== hdl/sopo_ctrl.sv =====
`timescale 1ns / 1ps
module sopo_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sopo_pkg::ctrl_status_t status,
    output sopo_pkg::ctrl_cmd_t    cmd
);
    import sopo_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.search_req)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = status.len_lt_shorter ? ST_SCAN : ST_OUT;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_JUDGE;
            end
            ST_JUDGE:
            begin
                state_next = status.accept_ok ? ST_OUT : ST_TEST;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_START:
            begin
                cmd.init_len = 1'b1;
            end
            ST_TEST:
            begin
                cmd.start_scan = status.len_lt_shorter;
                cmd.set_none = !status.len_lt_shorter;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = !status.scan_done;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_JUDGE:
            begin
                cmd.set_found = status.accept_ok;
                cmd.next_len = !status.accept_ok;
            end
            ST_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// ===== hdl/sopo_datapath.sv =====
`timescale 1ns / 1ps
module sopo_datapath
#(
    parameter int MAX_LEN = sopo_pkg::MAX_LEN_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sopo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sopo_pkg::CFG_DATA_W-1:0] cfg_data,
    sopo_word_if.sink                       in_word,
    sopo_result_if.source                   result,
    input  sopo_pkg::ctrl_cmd_t             cmd,
    output sopo_pkg::ctrl_status_t          status
);
    import sopo_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > 9) ? LW : 9;
    localparam int PA_W = CW + 13;
    localparam int PB_W = CW + 16;
    localparam int CMP_W = PA_W + 16;

    logic [8:0]  min_overlap_reg;
    logic [15:0] rate_reg;

    logic [7:0] first_mem [MAX_LEN];
    logic [7:0] second_mem [MAX_LEN];
    logic [7:0] rd1_reg;
    logic [7:0] rd2_reg;

    logic [LW-1:0] len1_reg;
    logic [LW-1:0] len2_reg;
    logic          done1_reg;
    logic          done2_reg;

    logic [9:0]  cc1_reg;
    logic [9:0]  cc2_reg;
    logic [30:0] cp1_reg;
    logic [30:0] cp2_reg;
    logic [8:0]  lc1_reg;
    logic [8:0]  lc2_reg;
    logic [15:0] ref1_reg;

    logic [CW-1:0]   len_reg;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   miss_reg;
    logic            pend_reg;
    logic [12:0]     sumc_reg;
    logic            zclip_reg;
    logic [PA_W-1:0] prod_a_reg;
    logic [PB_W-1:0] prod_b_reg;
    logic            found_reg;

    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [7:0]               out_len_reg;
    logic [7:0]               out_miss_reg;
    logic [15:0]              out_ref_reg;
    logic [30:0]              out_cp1_reg;
    logic [30:0]              out_cp2_reg;
    logic [9:0]               out_cc1_reg;
    logic [9:0]               out_cc2_reg;
    logic signed [9:0]        out_est_reg;

    logic          fire;
    logic [LW-1:0] cur_len;
    logic          cur_done;
    logic [LW-1:0] eff_len;
    logic          wr_en;
    logic [LW-1:0] new_len;
    logic [LW-1:0] shorter;
    logic [CW-1:0] addr1_full;
    logic [AW-1:0] addr1;
    logic [AW-1:0] addr2;
    logic [9:0]    cc_min;
    logic [9:0]    cc_max;
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    logic signed [15:0] est_wide;
    logic signed [9:0]  est_sat;

    assign in_word.ready = cmd.in_ready;
    assign fire = in_word.valid && cmd.in_ready;

    assign cur_len = in_word.which_sequence ? len2_reg : len1_reg;
    assign cur_done = in_word.which_sequence ? done2_reg : done1_reg;
    assign eff_len = cur_done ? '0 : cur_len;
    assign wr_en = fire && (eff_len < LW'(MAX_LEN));
    assign new_len = wr_en ? eff_len + 1'b1 : eff_len;

    assign shorter = (len1_reg < len2_reg) ? len1_reg : len2_reg;
    assign addr1_full = CW'(len1_reg) - len_reg + k_reg;
    assign addr1 = addr1_full[AW-1:0];
    assign addr2 = k_reg[AW-1:0];

    assign cc_min = (cc1_reg < cc2_reg) ? cc1_reg : cc2_reg;
    assign cc_max = (cc1_reg < cc2_reg) ? cc2_reg : cc1_reg;

    assign lhs = {prod_a_reg, 16'd0};
    assign rhs = CMP_W'({prod_b_reg, 2'b00}) + CMP_W'(prod_b_reg);

    assign est_wide = $signed(16'(len_reg)) - $signed(16'(lc1_reg)) - $signed(16'(lc2_reg));
    assign est_sat = (est_wide < -16'sd512) ? -10'sd512 :
                     (est_wide > 16'sd511) ? 10'sd511 : est_wide[9:0];

    assign status.search_req = fire && in_word.which_sequence && in_word.last;
    assign status.len_lt_shorter = len_reg < CW'(shorter);
    assign status.scan_done = (k_reg == len_reg);
    assign status.accept_ok = zclip_reg || (miss_reg == '0) || (lhs < rhs);
    assign status.out_free = !out_valid_reg || result.ready;

    // character stores
    always_ff @(posedge clk)
    begin
        if (wr_en && !in_word.which_sequence)
        begin
            first_mem[eff_len[AW-1:0]] <= in_word.base;
        end
        if (wr_en && in_word.which_sequence)
        begin
            second_mem[eff_len[AW-1:0]] <= in_word.base;
        end
        rd1_reg <= first_mem[addr1];
        rd2_reg <= second_mem[addr2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_overlap_reg <= MIN_OVERLAP_RESET;
            rate_reg <= MISMATCH_RATE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_OVERLAP:   min_overlap_reg <= cfg_data[8:0];
                CFG_MISMATCH_RATE: rate_reg <= cfg_data[15:0];
                default:           rate_reg <= rate_reg;
            endcase
        end
    end

    // sequence lengths and metadata
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg <= '0;
            len2_reg <= '0;
            done1_reg <= 1'b0;
            done2_reg <= 1'b0;
            cc1_reg <= '0;
            cc2_reg <= '0;
            cp1_reg <= '0;
            cp2_reg <= '0;
            lc1_reg <= '0;
            lc2_reg <= '0;
            ref1_reg <= '0;
        end
        else if (fire)
        begin
            if (in_word.which_sequence)
            begin
                len2_reg <= new_len;
                done2_reg <= in_word.last;
                if (in_word.last)
                begin
                    cc2_reg <= in_word.clip_count;
                    cp2_reg <= in_word.clip_position;
                    lc2_reg <= in_word.local_clip_position;
                end
            end
            else
            begin
                len1_reg <= new_len;
                done1_reg <= in_word.last;
                if (in_word.last)
                begin
                    cc1_reg <= in_word.clip_count;
                    cp1_reg <= in_word.clip_position;
                    lc1_reg <= in_word.local_clip_position;
                    ref1_reg <= in_word.reference_id;
                end
            end
        end
    end

    // search datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            k_reg <= '0;
            miss_reg <= '0;
            pend_reg <= 1'b0;
            sumc_reg <= '0;
            zclip_reg <= 1'b0;
            prod_a_reg <= '0;
            prod_b_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_issue;
            if (cmd.init_len)
            begin
                len_reg <= CW'(min_overlap_reg);
                sumc_reg <= 13'({cc_min, 2'b00}) + 13'(cc_max);
                zclip_reg <= (cc_min == '0) && (cc_max == '0);
            end
            else if (cmd.next_len)
            begin
                len_reg <= len_reg + 1'b1;
            end
            if (cmd.start_scan)
            begin
                k_reg <= '0;
                miss_reg <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                if (pend_reg && (rd1_reg != rd2_reg))
                begin
                    miss_reg <= miss_reg + 1'b1;
                end
            end
            if (cmd.mul)
            begin
                prod_a_reg <= PA_W'(miss_reg - 1'b1) * PA_W'(sumc_reg);
                prod_b_reg <= PB_W'(len_reg) * PB_W'(rate_reg);
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            else if (cmd.set_none)
            begin
                found_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_len_reg <= found_reg ? len_reg[7:0] : '0;
            out_miss_reg <= found_reg ? miss_reg[7:0] : '0;
            out_ref_reg <= found_reg ? ref1_reg : '0;
            out_cp1_reg <= found_reg ? cp1_reg : '0;
            out_cp2_reg <= found_reg ? cp2_reg : '0;
            out_cc1_reg <= found_reg ? cc1_reg : '0;
            out_cc2_reg <= found_reg ? cc2_reg : '0;
            out_est_reg <= found_reg ? est_sat : '0;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.found = out_found_reg;
    assign result.overlap_length = out_len_reg;
    assign result.mismatch_count = out_miss_reg;
    assign result.result_reference = out_ref_reg;
    assign result.first_clip_position = out_cp1_reg;
    assign result.second_clip_position = out_cp2_reg;
    assign result.first_clip_count = out_cc1_reg;
    assign result.second_clip_count = out_cc2_reg;
    assign result.estimated_length = out_est_reg;
endmodule

// ===== hdl/suffix_prefix_overlap_search.sv =====
`timescale 1ns / 1ps
// Loads two sequences one character word per cycle (which_sequence selects the
// store; last latches that sequence's metadata and ends it) and, on the last
// word of the second sequence, searches overlap lengths L upward from
// min_overlap_length while L is below the shorter length, returning one result
// word. The search walks both character memories one read port each, one
// character per cycle; each tried length L goes through setup, L reads plus one
// for the read latency, product and verdict. A start step comes before the
// search and a result load after it (after a final length test when no length
// is accepted); the result load waits while an earlier result word is still
// held, and input is held off while the search runs. Configure only while idle.
module suffix_prefix_overlap_search
#(
    parameter int MAX_LEN = sopo_pkg::MAX_LEN_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sopo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sopo_pkg::CFG_DATA_W-1:0] cfg_data,
    sopo_word_if.sink                       in_word,
    sopo_result_if.source                   result
);
    import sopo_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    sopo_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sopo_datapath #(.MAX_LEN(MAX_LEN)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .result    (result),
        .cmd       (cmd),
        .status    (status)
    );
endmodule
